// ----- src/box_average_downscaler_core_macros.svh -----
// Assertion macros for the box average downscaler.
// Included by files that carry concurrent assertions; expects i_clk and i_rst_n in scope.
`ifndef BOX_AVERAGE_DOWNSCALER_CORE_MACROS_SVH
`define BOX_AVERAGE_DOWNSCALER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define BXAVG_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bxavg: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define BXAVG_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bxavg: next-cycle check failed");
`else
`define BXAVG_ASSERT_IMP(label, ante, cons)
`define BXAVG_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- src/bxavg_pkg.sv -----
// Shared constants, register codes and types of the box average downscaler.
// Has no dependencies; every other RTL file imports it.
package bxavg_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_SCALE_DEF = 16;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int HEIGHT_W      = $clog2(HEIGHT_LIMIT + 1);
    localparam int ROW_W         = $clog2(HEIGHT_LIMIT);

    localparam int PIXEL_W    = 8;
    localparam int DIM_W      = 13;
    localparam int SCALE_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE   = 2'd3;

    localparam logic [DIM_W-1:0]   RST_IN_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IN_HEIGHT = 13'd480;
    localparam logic [SCALE_W-1:0] RST_X_SCALE   = 5'd2;
    localparam logic [SCALE_W-1:0] RST_Y_SCALE   = 5'd2;

    // Classification of one finished row segment of a block.
    typedef struct packed {
        logic first;       // top row of the band: overwrite the column sum
        logic emit;        // bottom row of the band: block is complete
        logic row_last;    // last output column
        logic frame_last;  // last output of the frame
    } t_op_flags;

endpackage

// ----- src/box_average_downscaler_core.sv -----
// Top level of the box average downscaler: configuration, front end, queue, back end.
// Depends on bxavg_pkg, bxavg_cfg, bxavg_front, bxavg_fifo, bxavg_back and the macros header.
//
// Usage. Greyscale pixels enter in raster order on the slave stream, one item per
// tdata byte. Each output item is the floored mean of one x_scale by y_scale block
// and leaves on the master stream once the bottom-right pixel of its block is taken;
// tuser flags the last output of an output row and tlast the last output of a frame.
// Pixels right of the last whole block and rows below the last whole band produce
// nothing; a frame smaller than one block produces no output.
// Throughput is one pixel per clock while tready is high. A result passes from the
// pixel that completes its block through the queue, the column sum memory
// read-modify-write, the reciprocal multiply and the output register.
// After reset, and after every configuration write, the geometry (output width and
// height) and the reciprocal of the block area are computed by a one-bit-per-cycle
// divider shared over three divisions; tready stays low until all three are done.
// A write also restarts the frame position.
// A stalled receiver halts the whole back pipeline in place; the four-entry queue then
// fills, after which tready drops until the receiver takes items.
// The column sum memory needs no clearing: the top row of each band writes it first.
`include "box_average_downscaler_core_macros.svh"
module box_average_downscaler_core #(
    parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bxavg_pkg::MAX_SCALE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [bxavg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bxavg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // Slave stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [bxavg_pkg::PIXEL_W-1:0]     i_s_tdata,   // [7:0] pixel
    // Master stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [bxavg_pkg::PIXEL_W-1:0]     o_m_tdata,   // [7:0] average
    output logic                              o_m_tlast,   // frame_end
    output logic                              o_m_tuser    // [0] row_end
);
    import bxavg_pkg::*;

    localparam int WCL_W  = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int SC_W   = $clog2(MAX_SCALE + 1);
    localparam int PART_W = PIXEL_W + $clog2(MAX_SCALE);
    localparam int SUM_W  = PIXEL_W + 2 * $clog2(MAX_SCALE);
    localparam int PROD_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
    localparam int REC_W  = SUM_W + PROD_W + 1;
    localparam int FLG_W  = $bits(t_op_flags);
    localparam int Q_W    = FLG_W + CW + PART_W;

    // Geometry from the configuration unit.
    logic                cfg_busy;
    logic [WCL_W-1:0]    geo_width;
    logic [WCL_W-1:0]    geo_ow_m1;
    logic [WCL_W-1:0]    geo_ow_xs;
    logic [HEIGHT_W-1:0] geo_height;
    logic [HEIGHT_W-1:0] geo_oh_ys;
    logic [SC_W-1:0]     geo_xs;
    logic [SC_W-1:0]     geo_ys;
    logic [REC_W-1:0]    geo_recip;

    // Front end to queue.
    logic              in_accept;
    logic              fr_push;
    logic [CW-1:0]     fr_oc;
    logic [PART_W-1:0] fr_partial;
    t_op_flags         fr_flags;

    // Queue to back end.
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic [Q_W-1:0]    q_data;
    t_op_flags         bk_flags;
    logic [CW-1:0]     bk_oc;
    logic [PART_W-1:0] bk_partial;

    // Pixels are taken only with geometry settled and room in the queue.
    assign o_s_tready = !cfg_busy && !q_full;
    assign in_accept  = i_s_tvalid && o_s_tready;

    bxavg_cfg #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (i_cfg_we),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_busy   (cfg_busy),
        .o_width  (geo_width),
        .o_ow_m1  (geo_ow_m1),
        .o_ow_xs  (geo_ow_xs),
        .o_height (geo_height),
        .o_oh_ys  (geo_oh_ys),
        .o_xs     (geo_xs),
        .o_ys     (geo_ys),
        .o_recip  (geo_recip)
    );

    bxavg_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_accept  (in_accept),
        .i_pixel   (i_s_tdata),
        .i_width   (geo_width),
        .i_ow_m1   (geo_ow_m1),
        .i_ow_xs   (geo_ow_xs),
        .i_height  (geo_height),
        .i_oh_ys   (geo_oh_ys),
        .i_xs      (geo_xs),
        .i_ys      (geo_ys),
        .o_push    (fr_push),
        .o_oc      (fr_oc),
        .o_partial (fr_partial),
        .o_flags   (fr_flags)
    );

    bxavg_fifo #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_data  ({fr_flags, fr_oc, fr_partial}),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign bk_flags   = q_data[Q_W-1 -: FLG_W];
    assign bk_oc      = q_data[PART_W +: CW];
    assign bk_partial = q_data[PART_W-1:0];

    bxavg_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!q_empty),
        .i_oc         (bk_oc),
        .i_partial    (bk_partial),
        .i_flags      (bk_flags),
        .i_recip      (geo_recip),
        .o_pop        (q_pop),
        .i_out_ready  (i_m_tready),
        .o_out_valid  (o_m_tvalid),
        .o_average    (o_m_tdata),
        .o_row_last   (o_m_tuser),
        .o_frame_last (o_m_tlast)
    );

    // A configuration write always recomputes geometry before pixels are taken again.
    `BXAVG_ASSERT_NXT(a_cfg_blocks_input, i_cfg_we, !o_s_tready)
    // The front end never pushes into a full queue.
    `BXAVG_ASSERT_IMP(a_no_queue_overflow, fr_push, !q_full)
    // The last output of a frame is also the last output of its row.
    `BXAVG_ASSERT_IMP(a_frame_end_is_row_end, o_m_tvalid && o_m_tlast, o_m_tuser)

endmodule

// ----- src/bxavg_cfg.sv -----
// Configuration registers and the serial divider that derives the frame geometry
// and the averaging reciprocal. Depends on bxavg_pkg.
module bxavg_cfg #(
    parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bxavg_pkg::MAX_SCALE_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_we,
    input  logic [bxavg_pkg::CFG_IDX_W-1:0]       i_index,
    input  logic [bxavg_pkg::CFG_DATA_W-1:0]      i_data,
    output logic                                  o_busy,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        o_width,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        o_ow_m1,
    output logic [$clog2(MAX_WIDTH+1)-1:0]        o_ow_xs,
    output logic [bxavg_pkg::HEIGHT_W-1:0]        o_height,
    output logic [bxavg_pkg::HEIGHT_W-1:0]        o_oh_ys,
    output logic [$clog2(MAX_SCALE+1)-1:0]        o_xs,
    output logic [$clog2(MAX_SCALE+1)-1:0]        o_ys,
    output logic [bxavg_pkg::PIXEL_W + 2*$clog2(MAX_SCALE)
                  + $clog2(MAX_SCALE*MAX_SCALE+1):0] o_recip
);
    import bxavg_pkg::*;

    localparam int WCL_W  = $clog2(MAX_WIDTH + 1);
    localparam int SC_W   = $clog2(MAX_SCALE + 1);
    localparam int SUM_W  = PIXEL_W + 2 * $clog2(MAX_SCALE);
    localparam int PROD_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
    localparam int K      = SUM_W + PROD_W;
    localparam int REC_W  = K + 1;
    localparam int DIV_W  = (K > WCL_W) ? K : WCL_W;
    localparam int CNT_W  = $clog2(DIV_W + 1);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_W     = 3'd2;
    localparam logic [2:0] PH_H     = 3'd3;
    localparam logic [2:0] PH_R     = 3'd4;

    function automatic logic [WCL_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) return WCL_W'(1);
        if (v32 > 32'(MAX_WIDTH)) return WCL_W'(MAX_WIDTH);
        return WCL_W'(v32);
    endfunction

    function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) return HEIGHT_W'(1);
        if (v32 > 32'(HEIGHT_LIMIT)) return HEIGHT_W'(HEIGHT_LIMIT);
        return HEIGHT_W'(v32);
    endfunction

    function automatic logic [SC_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
        logic [31:0] v32;
        v32 = 32'(v);
        if (v32 == 32'd0) return SC_W'(1);
        if (v32 > 32'(MAX_SCALE)) return SC_W'(MAX_SCALE);
        return SC_W'(v32);
    endfunction

    logic [WCL_W-1:0]    r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [SC_W-1:0]     r_xs;
    logic [SC_W-1:0]     r_ys;
    logic [PROD_W-1:0]   r_area;
    logic [2:0]          r_phase;
    logic [CNT_W-1:0]    r_cnt;
    logic [PROD_W-1:0]   r_rem;
    logic [DIV_W-1:0]    r_quo;
    logic [WCL_W-1:0]    r_ow_m1;
    logic [WCL_W-1:0]    r_ow_xs;
    logic [HEIGHT_W-1:0] r_oh_ys;
    logic [REC_W-1:0]    r_recip;

    logic [PROD_W-1:0] divisor;
    logic [PROD_W:0]   rem_sh;
    logic [PROD_W:0]   rem_sub;
    logic              ge;

    always_comb begin
        unique case (r_phase)
            PH_W:    divisor = PROD_W'(r_xs);
            PH_H:    divisor = PROD_W'(r_ys);
            default: divisor = r_area;
        endcase
        rem_sh  = {r_rem, r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, divisor};
        ge      = rem_sh >= {1'b0, divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= clamp_width(RST_IN_WIDTH);
            r_height <= clamp_height(RST_IN_HEIGHT);
            r_xs     <= clamp_scale(RST_X_SCALE);
            r_ys     <= clamp_scale(RST_Y_SCALE);
        end else if (i_we) begin
            unique case (i_index)
                REG_IN_WIDTH:  r_width  <= clamp_width(i_data);
                REG_IN_HEIGHT: r_height <= clamp_height(i_data);
                REG_X_SCALE:   r_xs     <= clamp_scale(i_data[SCALE_W-1:0]);
                REG_Y_SCALE:   r_ys     <= clamp_scale(i_data[SCALE_W-1:0]);
            endcase
        end
    end

    // Sequencer: three divisions in turn, each one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_cnt   <= '0;
        end else if (i_we) begin
            r_phase <= PH_START;
        end else begin
            unique case (r_phase) inside
                PH_IDLE: begin
                end
                PH_START: begin
                    r_phase <= PH_W;
                    r_cnt   <= CNT_W'(DIV_W);
                end
                PH_W, PH_H, PH_R: begin
                    if (r_cnt != '0) begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end else begin
                        r_cnt <= CNT_W'(DIV_W);
                        if (r_phase == PH_W) begin
                            r_phase <= PH_H;
                        end else if (r_phase == PH_H) begin
                            r_phase <= PH_R;
                        end else begin
                            r_phase <= PH_IDLE;
                        end
                    end
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_area <= PROD_W'(r_xs) * PROD_W'(r_ys);
        if (r_phase == PH_START) begin
            r_quo <= DIV_W'(r_width);
            r_rem <= '0;
        end else if (r_phase == PH_W || r_phase == PH_H || r_phase == PH_R) begin
            if (r_cnt != '0) begin
                r_rem <= ge ? rem_sub[PROD_W-1:0] : rem_sh[PROD_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], ge};
            end else begin
                r_rem <= '0;
                if (r_phase == PH_W) begin
                    r_ow_m1 <= WCL_W'(r_quo) - WCL_W'(1);
                    r_ow_xs <= r_width - WCL_W'(r_rem);
                    r_quo   <= DIV_W'(r_height);
                end else if (r_phase == PH_H) begin
                    r_oh_ys <= r_height - HEIGHT_W'(r_rem);
                    // All ones below bit K: the ceiling of 2^K / area is this quotient plus one.
                    r_quo   <= ~DIV_W'(0) >> (DIV_W - K);
                end else begin
                    r_recip <= REC_W'(r_quo[K-1:0]) + REC_W'(1);
                end
            end
        end
    end

    assign o_busy   = r_phase != PH_IDLE;
    assign o_width  = r_width;
    assign o_height = r_height;
    assign o_xs     = r_xs;
    assign o_ys     = r_ys;
    assign o_ow_m1  = r_ow_m1;
    assign o_ow_xs  = r_ow_xs;
    assign o_oh_ys  = r_oh_ys;
    assign o_recip  = r_recip;

endmodule

// ----- src/bxavg_front.sv -----
// Front end: raster position counters and per-row block sums; classifies each
// finished row segment of a block for the back end. Depends on bxavg_pkg.
module bxavg_front #(
    parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bxavg_pkg::MAX_SCALE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_restart,
    input  logic                                   i_accept,
    input  logic [bxavg_pkg::PIXEL_W-1:0]          i_pixel,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_width,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_ow_m1,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]         i_ow_xs,
    input  logic [bxavg_pkg::HEIGHT_W-1:0]         i_height,
    input  logic [bxavg_pkg::HEIGHT_W-1:0]         i_oh_ys,
    input  logic [$clog2(MAX_SCALE+1)-1:0]         i_xs,
    input  logic [$clog2(MAX_SCALE+1)-1:0]         i_ys,
    output logic                                   o_push,
    output logic [$clog2(MAX_WIDTH)-1:0]           o_oc,
    output logic [bxavg_pkg::PIXEL_W+$clog2(MAX_SCALE)-1:0] o_partial,
    output bxavg_pkg::t_op_flags                   o_flags
);
    import bxavg_pkg::*;

    localparam int WCL_W  = $clog2(MAX_WIDTH + 1);
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int SC_W   = $clog2(MAX_SCALE + 1);
    localparam int SUB_W  = $clog2(MAX_SCALE);
    localparam int PART_W = PIXEL_W + $clog2(MAX_SCALE);

    logic [CW-1:0]     r_in_col;
    logic [ROW_W-1:0]  r_in_row;
    logic [SUB_W-1:0]  r_sub_col;
    logic [SUB_W-1:0]  r_sub_row;
    logic [CW-1:0]     r_out_col;
    logic [PART_W-1:0] r_part;

    logic              in_region;
    logic              col_done;
    logic              row_last;
    logic              line_end;
    logic              frame_bottom;
    logic              sub_col_wrap;
    logic              sub_row_wrap;
    logic [PART_W-1:0] part_sum;

    always_comb begin
        in_region    = (WCL_W'(r_in_col) < i_ow_xs) && (HEIGHT_W'(r_in_row) < i_oh_ys);
        part_sum     = r_part + PART_W'(i_pixel);
        col_done     = in_region && (SC_W'(r_sub_col) == i_xs - SC_W'(1));
        row_last     = WCL_W'(r_out_col) == i_ow_m1;
        line_end     = (WCL_W'(r_in_col) + WCL_W'(1)) >= i_width;
        frame_bottom = (HEIGHT_W'(r_in_row) + HEIGHT_W'(1)) >= i_height;
        sub_col_wrap = (SC_W'(r_sub_col) + SC_W'(1)) >= i_xs;
        sub_row_wrap = (SC_W'(r_sub_row) + SC_W'(1)) >= i_ys;

        o_push             = i_accept && col_done;
        o_oc               = r_out_col;
        o_partial          = part_sum;
        o_flags.first      = r_sub_row == '0;
        o_flags.emit       = SC_W'(r_sub_row) == i_ys - SC_W'(1);
        o_flags.row_last   = row_last;
        o_flags.frame_last = row_last && (HEIGHT_W'(r_in_row) == i_oh_ys - HEIGHT_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_sub_col <= '0;
            r_sub_row <= '0;
            r_out_col <= '0;
            r_part    <= '0;
        end else if (i_accept) begin
            if (in_region) begin
                if (col_done) begin
                    r_part    <= '0;
                    r_out_col <= r_out_col + CW'(1);
                end else begin
                    r_part <= part_sum;
                end
            end
            // The end of an input line overrides the block bookkeeping above.
            if (line_end) begin
                r_in_col  <= '0;
                r_sub_col <= '0;
                r_out_col <= '0;
                r_part    <= '0;
                if (frame_bottom) begin
                    r_in_row  <= '0;
                    r_sub_row <= '0;
                end else begin
                    r_in_row  <= r_in_row + ROW_W'(1);
                    r_sub_row <= sub_row_wrap ? '0 : r_sub_row + SUB_W'(1);
                end
            end else begin
                r_in_col  <= r_in_col + CW'(1);
                r_sub_col <= sub_col_wrap ? '0 : r_sub_col + SUB_W'(1);
            end
        end
    end

endmodule

// ----- src/bxavg_fifo.sv -----
// Short queue of classified operations between the front and back ends.
// Depends on bxavg_pkg for its default depth.
module bxavg_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = bxavg_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty,
    output logic              o_full
);
    import bxavg_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_slots [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_empty = r_count == '0;
    assign o_full  = r_count == CNT_W'(DEPTH);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slots[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ----- src/bxavg_back.sv -----
// Back end: column sum memory read-modify-write, reciprocal multiply for the
// block mean, and the output register. Depends on bxavg_pkg.
module bxavg_back #(
    parameter int MAX_WIDTH = bxavg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_SCALE = bxavg_pkg::MAX_SCALE_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]           i_oc,
    input  logic [bxavg_pkg::PIXEL_W+$clog2(MAX_SCALE)-1:0] i_partial,
    input  bxavg_pkg::t_op_flags                   i_flags,
    input  logic [bxavg_pkg::PIXEL_W + 2*$clog2(MAX_SCALE)
                  + $clog2(MAX_SCALE*MAX_SCALE+1):0] i_recip,
    output logic                                   o_pop,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic [bxavg_pkg::PIXEL_W-1:0]          o_average,
    output logic                                   o_row_last,
    output logic                                   o_frame_last
);
    import bxavg_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int PART_W = PIXEL_W + $clog2(MAX_SCALE);
    localparam int SUM_W  = PIXEL_W + 2 * $clog2(MAX_SCALE);
    localparam int PROD_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
    localparam int K      = SUM_W + PROD_W;
    localparam int REC_W  = K + 1;
    localparam int MUL_W  = SUM_W + REC_W;

    logic [SUM_W-1:0] r_col_sums [MAX_WIDTH];
    logic [SUM_W-1:0] r_rdata;

    logic              r_s1_valid;
    logic [CW-1:0]     r_s1_oc;
    logic [PART_W-1:0] r_s1_partial;
    t_op_flags         r_s1_flags;
    logic              r_fwd;
    logic [SUM_W-1:0]  r_fwd_data;

    logic              r_s2_valid;
    logic [SUM_W-1:0]  r_s2_sum;
    logic              r_s2_row_last;
    logic              r_s2_frame_last;

    logic              r_s3_valid;
    logic [MUL_W-1:0]  r_s3_prod;
    logic              r_s3_row_last;
    logic              r_s3_frame_last;

    logic               r_out_valid;
    logic [PIXEL_W-1:0] r_out_avg;
    logic               r_out_row_last;
    logic               r_out_frame_last;

    logic             pipe_en;
    logic [SUM_W-1:0] base;
    logic [SUM_W-1:0] s1_sum;

    // The whole pipe advances together; it halts only while a result waits.
    assign pipe_en = !r_out_valid || i_out_ready;
    assign o_pop   = pipe_en && i_valid;

    always_comb begin
        base   = r_fwd ? r_fwd_data : r_rdata;
        s1_sum = r_s1_flags.first ? SUM_W'(r_s1_partial) : base + SUM_W'(r_s1_partial);
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            if (r_s1_valid) begin
                r_col_sums[r_s1_oc] <= s1_sum;
            end
            r_rdata <= r_col_sums[i_oc];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (pipe_en) begin
            r_s1_valid  <= o_pop;
            // A read in the same cycle as a write to that column sees the old
            // value, so the fresh sum is carried over to the next stage.
            r_fwd       <= o_pop && r_s1_valid && (i_oc == r_s1_oc);
            r_s2_valid  <= r_s1_valid && r_s1_flags.emit;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_s1_oc          <= i_oc;
            r_s1_partial     <= i_partial;
            r_s1_flags       <= i_flags;
            r_fwd_data       <= s1_sum;
            r_s2_sum         <= s1_sum;
            r_s2_row_last    <= r_s1_flags.row_last;
            r_s2_frame_last  <= r_s1_flags.frame_last;
            r_s3_prod        <= MUL_W'(r_s2_sum) * MUL_W'(i_recip);
            r_s3_row_last    <= r_s2_row_last;
            r_s3_frame_last  <= r_s2_frame_last;
            r_out_avg        <= r_s3_prod[K +: PIXEL_W];
            r_out_row_last   <= r_s3_row_last;
            r_out_frame_last <= r_s3_frame_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_average    = r_out_avg;
    assign o_row_last   = r_out_row_last;
    assign o_frame_last = r_out_frame_last;

endmodule
